### rtl/skeleton_global_to_local_rotation_core_defines.svh
// Assertion macros shared by the checker of the rotation core.
`ifndef SKELETON_GLOBAL_TO_LOCAL_ROTATION_CORE_DEFINES_SVH
`define SKELETON_GLOBAL_TO_LOCAL_ROTATION_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SKL_G2L_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SKL_G2L_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/skl_g2l_pkg.sv
// Types, constants and helper functions of the skeleton rotation core.
package skl_g2l_pkg;

    localparam int COMP_W    = 16;
    localparam int FRAC_BITS = COMP_W - 2;
    localparam logic [5:0] COUNT_MAX = 6'd63;

    // Component selects of a quaternion.
    localparam logic [1:0] C_X = 2'd0;
    localparam logic [1:0] C_Y = 2'd1;
    localparam logic [1:0] C_Z = 2'd2;
    localparam logic [1:0] C_W = 2'd3;

    // Accumulator destinations.
    localparam logic [2:0] D_H0 = 3'd0;
    localparam logic [2:0] D_H1 = 3'd1;
    localparam logic [2:0] D_H2 = 3'd2;
    localparam logic [2:0] D_H3 = 3'd3;
    localparam logic [2:0] D_N  = 3'd4;

    localparam logic [4:0] MAC_STEPS = 5'd20;

    typedef struct packed {
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] z;
        logic signed [COMP_W-1:0] w;
    } quat_t;

    typedef struct packed {
        logic [4:0]               joint_index;
        logic [4:0]               parent_index;
        logic signed [COMP_W-1:0] qx;
        logic signed [COMP_W-1:0] qy;
        logic signed [COMP_W-1:0] qz;
        logic signed [COMP_W-1:0] qw;
        logic                     frame_end;
    } item_t;

    typedef struct packed {
        logic [4:0]               out_joint;
        logic signed [COMP_W-1:0] lx;
        logic signed [COMP_W-1:0] ly;
        logic signed [COMP_W-1:0] lz;
        logic signed [COMP_W-1:0] lw;
        logic                     run_end;
        logic                     count_error;
    } result_t;

    // Table write request from the front end.
    typedef struct packed {
        logic       en;
        logic [4:0] joint;
        logic [4:0] parent;
        quat_t      q;
    } wr_t;

    // One finished frame handed to the back end.
    typedef struct packed {
        logic       err;
        logic [5:0] total;
    } job_t;

    // One multiply-accumulate step: p.a times (p or g).b, added or subtracted.
    typedef struct packed {
        logic [1:0] a;
        logic [1:0] b;
        logic       use_p;
        logic       neg;
        logic [2:0] dst;
    } mac_term_t;

    function automatic logic signed [COMP_W-1:0] comp_sel(quat_t q, logic [1:0] s);
        logic signed [COMP_W-1:0] v;
        unique case (s)
            C_X: v = q.x;
            C_Y: v = q.y;
            C_Z: v = q.z;
            C_W: v = q.w;
            default: v = q.w;
        endcase
        return v;
    endfunction

    // conj(P) * G expanded on the parent components, followed by |P|^2.
    function automatic mac_term_t mac_term(logic [4:0] k);
        mac_term_t t;
        unique case (k)
            5'd0:  t = '{a: C_W, b: C_X, use_p: 1'b0, neg: 1'b0, dst: D_H0};
            5'd1:  t = '{a: C_X, b: C_W, use_p: 1'b0, neg: 1'b1, dst: D_H0};
            5'd2:  t = '{a: C_Y, b: C_Z, use_p: 1'b0, neg: 1'b1, dst: D_H0};
            5'd3:  t = '{a: C_Z, b: C_Y, use_p: 1'b0, neg: 1'b0, dst: D_H0};
            5'd4:  t = '{a: C_W, b: C_Y, use_p: 1'b0, neg: 1'b0, dst: D_H1};
            5'd5:  t = '{a: C_Y, b: C_W, use_p: 1'b0, neg: 1'b1, dst: D_H1};
            5'd6:  t = '{a: C_Z, b: C_X, use_p: 1'b0, neg: 1'b1, dst: D_H1};
            5'd7:  t = '{a: C_X, b: C_Z, use_p: 1'b0, neg: 1'b0, dst: D_H1};
            5'd8:  t = '{a: C_W, b: C_Z, use_p: 1'b0, neg: 1'b0, dst: D_H2};
            5'd9:  t = '{a: C_Z, b: C_W, use_p: 1'b0, neg: 1'b1, dst: D_H2};
            5'd10: t = '{a: C_X, b: C_Y, use_p: 1'b0, neg: 1'b1, dst: D_H2};
            5'd11: t = '{a: C_Y, b: C_X, use_p: 1'b0, neg: 1'b0, dst: D_H2};
            5'd12: t = '{a: C_W, b: C_W, use_p: 1'b0, neg: 1'b0, dst: D_H3};
            5'd13: t = '{a: C_X, b: C_X, use_p: 1'b0, neg: 1'b0, dst: D_H3};
            5'd14: t = '{a: C_Y, b: C_Y, use_p: 1'b0, neg: 1'b0, dst: D_H3};
            5'd15: t = '{a: C_Z, b: C_Z, use_p: 1'b0, neg: 1'b0, dst: D_H3};
            5'd16: t = '{a: C_X, b: C_X, use_p: 1'b1, neg: 1'b0, dst: D_N};
            5'd17: t = '{a: C_Y, b: C_Y, use_p: 1'b1, neg: 1'b0, dst: D_N};
            5'd18: t = '{a: C_Z, b: C_Z, use_p: 1'b1, neg: 1'b0, dst: D_N};
            5'd19: t = '{a: C_W, b: C_W, use_p: 1'b1, neg: 1'b0, dst: D_N};
            default: t = '{a: C_W, b: C_W, use_p: 1'b1, neg: 1'b0, dst: D_N};
        endcase
        return t;
    endfunction

endpackage

### rtl/skeleton_global_to_local_rotation_core.sv
// Top level of the skeleton global-to-local joint rotation core.
//
//  Channel   Signals                         Moves
//  item      item_valid/item_stall/item      one joint global rotation request
//  result    result_valid/result_stall/result one local rotation request
//  cfg       cfg_valid/cfg_ready/cfg_data    write of joint_total
//
// Loading takes one joint per cycle while items are not stalled. After the
// frame's last joint the table is busy until the last local is in the output
// register: a root joint or one with an out-of-range parent is copied, and
// any other joint is worked out by the single shared 16x16 multiplier (20
// products) and the radix-2 divider (four quotients, one bit per step). The
// first joint of a frame also waits for the job to be taken. Reset is
// asynchronous and active low; it clears the frame count, the job queue and
// the sequencer, not the table. A stalled result holds in the output register
// while the next local is worked out; items are stalled while a frame is queued or being emitted.
module skeleton_global_to_local_rotation_core #(
    parameter int MAX_JOINTS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  skl_g2l_pkg::item_t   item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output skl_g2l_pkg::result_t result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [5:0]           cfg_data
);

    // Table writes go straight from the front end into the back end's memory.
    skl_g2l_pkg::wr_t  wr;
    skl_g2l_pkg::job_t push_job;
    skl_g2l_pkg::job_t head_job;
    logic              job_push;
    logic              job_valid;
    logic              job_pop;
    logic              back_busy;

    // The front end counts each frame and turns its last item into a job.
    skl_g2l_front #(
        .MAX_JOINTS (MAX_JOINTS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .job_pending (job_valid),
        .back_busy   (back_busy),
        .wr          (wr),
        .job_push    (job_push),
        .job         (push_job)
    );

    // Short queue that separates frame acceptance from result generation.
    skl_g2l_jobq u_jobq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_job  (push_job),
        .pop       (job_pop),
        .job_valid (job_valid),
        .job       (head_job)
    );

    // The back end walks the joints in order and produces one local each, or a single error result for a bad frame.
    skl_g2l_back #(
        .MAX_JOINTS (MAX_JOINTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr           (wr),
        .job_valid    (job_valid),
        .job          (head_job),
        .job_pop      (job_pop),
        .busy         (back_busy),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

### rtl/skl_g2l_front.sv
// Front end: accepts joint items, counts the frame and issues frame jobs.
module skl_g2l_front #(
    parameter int MAX_JOINTS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  skl_g2l_pkg::item_t  item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [5:0]          cfg_data,
    input  logic                job_pending,
    input  logic                back_busy,
    output skl_g2l_pkg::wr_t    wr,
    output logic                job_push,
    output skl_g2l_pkg::job_t   job
);

    logic [5:0] total_reg;
    logic [5:0] count_reg;
    logic [5:0] count_next;
    logic       accept;

    // The table belongs to one frame at a time.
    assign item_stall = job_pending | back_busy;
    assign cfg_ready  = 1'b1;
    assign accept     = item_valid & ~item_stall;

    assign count_next = (count_reg == skl_g2l_pkg::COUNT_MAX) ? count_reg : count_reg + 6'd1;

    assign wr.en     = accept;
    assign wr.joint  = item.joint_index;
    assign wr.parent = item.parent_index;
    assign wr.q      = '{x: item.qx, y: item.qy, z: item.qz, w: item.qw};

    assign job_push  = accept & item.frame_end;
    assign job.total = total_reg;
    assign job.err   = (count_next != total_reg) || (total_reg == 6'd0)
                       || ({1'b0, total_reg} > 7'(MAX_JOINTS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= 6'd1;
            count_reg <= 6'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                total_reg <= cfg_data;
            end
            if (accept)
            begin
                count_reg <= item.frame_end ? 6'd0 : count_next;
            end
        end
    end

endmodule

### rtl/skl_g2l_jobq.sv
// Two-entry queue of frame jobs between the front and back ends.
module skl_g2l_jobq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  skl_g2l_pkg::job_t  push_job,
    input  logic               pop,
    output logic               job_valid,
    output skl_g2l_pkg::job_t  job
);

    skl_g2l_pkg::job_t entry_reg [2];
    logic              wp_reg;
    logic              rp_reg;
    logic [1:0]        cnt_reg;
    logic              do_push;
    logic              do_pop;

    assign job_valid = cnt_reg != 2'd0;
    assign job       = entry_reg[rp_reg];
    assign do_push   = push && (cnt_reg != 2'd2);
    assign do_pop    = pop && job_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wp_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (do_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

### rtl/skl_g2l_back.sv
// Back end: rotation table, shared multiplier, radix-2 divider and result register.
module skl_g2l_back #(
    parameter int MAX_JOINTS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  skl_g2l_pkg::wr_t     wr,
    input  logic                 job_valid,
    input  skl_g2l_pkg::job_t    job,
    output logic                 job_pop,
    output logic                 busy,
    output logic                 result_valid,
    input  logic                 result_stall,
    output skl_g2l_pkg::result_t result
);

    localparam int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    localparam int CW = skl_g2l_pkg::COMP_W;
    localparam int AccW = 2 * CW + 3;
    localparam int DivW = AccW + skl_g2l_pkg::FRAC_BITS + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_G, S_RD_P, S_SEL, S_MAC, S_DRAIN, S_DSET, S_DIT, S_EMIT
    } state_t;

    skl_g2l_pkg::quat_t gmem [MAX_JOINTS];
    logic [4:0]         pmem [MAX_JOINTS];

    state_t                  state_reg;
    skl_g2l_pkg::quat_t      g_reg;
    skl_g2l_pkg::quat_t      p_reg;
    logic [4:0]              par_reg;
    logic [5:0]              j_reg;
    logic [5:0]              total_reg;
    logic                    err_reg;
    logic [4:0]              k_reg;
    logic signed [2*CW-1:0]  prod_reg;
    logic                    prod_v_reg;
    logic                    prod_neg_reg;
    logic [2:0]              prod_dst_reg;
    logic signed [AccW-1:0]  acc_reg [5];
    logic [1:0]              c_reg;
    logic [DivW-1:0]         rem_reg;
    logic [DivW-1:0]         dv_reg;
    logic [CW-1:0]           q_reg;
    logic [3:0]              i_reg;
    logic                    neg_reg;
    logic signed [CW-1:0]    res_reg [4];
    logic                    out_valid_reg;
    skl_g2l_pkg::result_t    out_reg;

    logic [6:0]              wj;
    logic [6:0]              rj;
    logic [6:0]              rp;
    logic                    par_oob;
    skl_g2l_pkg::mac_term_t  mt;
    logic signed [CW-1:0]    mul_a;
    logic signed [CW-1:0]    mul_b;
    logic signed [2*CW-1:0]  mul_p;
    logic signed [AccW-1:0]  h_cur;
    logic [AccW-1:0]         n_cur;
    logic [AccW-1:0]         mag;
    logic                    ge;
    logic [CW-1:0]           qf;
    logic [CW-1:0]           qs;
    logic signed [CW-1:0]    qres;
    logic                    emit_go;
    logic                    last_joint;

    assign wj      = {2'b00, wr.joint};
    assign rj      = {1'b0, j_reg};
    assign rp      = {2'b00, par_reg};
    assign par_oob = rp >= 7'(MAX_JOINTS);

    // Table: one write port, two registered read ports (joint and its parent).
    always_ff @(posedge clk)
    begin
        if (wr.en && (wj < 7'(MAX_JOINTS)))
        begin
            gmem[wj[AW-1:0]] <= wr.q;
            pmem[wj[AW-1:0]] <= wr.parent;
        end
        if (state_reg == S_RD_G)
        begin
            g_reg   <= gmem[rj[AW-1:0]];
            par_reg <= pmem[rj[AW-1:0]];
        end
        if (state_reg == S_RD_P)
        begin
            p_reg <= gmem[rp[AW-1:0]];
        end
    end

    always_comb
    begin
        mt    = skl_g2l_pkg::mac_term(k_reg);
        mul_a = skl_g2l_pkg::comp_sel(p_reg, mt.a);
        mul_b = mt.use_p ? skl_g2l_pkg::comp_sel(p_reg, mt.b)
                         : skl_g2l_pkg::comp_sel(g_reg, mt.b);
        mul_p = mul_a * mul_b;
    end

    always_comb
    begin
        h_cur = acc_reg[c_reg];
        n_cur = acc_reg[skl_g2l_pkg::D_N];
        mag   = (h_cur < 0) ? AccW'(-h_cur) : AccW'(h_cur);
        ge    = rem_reg >= dv_reg;
        qf    = {q_reg[CW-2:0], ge};
        if (neg_reg)
        begin
            qs = (qf > {1'b1, {(CW-1){1'b0}}}) ? {1'b1, {(CW-1){1'b0}}} : qf;
        end
        else
        begin
            qs = (qf > {1'b0, {(CW-1){1'b1}}}) ? {1'b0, {(CW-1){1'b1}}} : qf;
        end
        qres = neg_reg ? -$signed(qs) : $signed(qs);
    end

    assign emit_go      = !out_valid_reg || !result_stall;
    assign last_joint   = (j_reg + 6'd1) == total_reg;
    assign job_pop      = (state_reg == S_IDLE) && job_valid;
    assign busy         = state_reg != S_IDLE;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            j_reg         <= 6'd0;
            total_reg     <= 6'd0;
            err_reg       <= 1'b0;
            k_reg         <= 5'd0;
            prod_reg      <= '0;
            prod_v_reg    <= 1'b0;
            prod_neg_reg  <= 1'b0;
            prod_dst_reg  <= 3'd0;
            for (int a = 0; a < 5; a++)
            begin
                acc_reg[a] <= '0;
            end
            c_reg         <= 2'd0;
            rem_reg       <= '0;
            dv_reg        <= '0;
            q_reg         <= '0;
            i_reg         <= 4'd0;
            neg_reg       <= 1'b0;
            for (int a = 0; a < 4; a++)
            begin
                res_reg[a] <= '0;
            end
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            // In the emit state the result register is handled below.
            if (out_valid_reg && !result_stall && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            prod_v_reg <= (state_reg == S_MAC);
            if (prod_v_reg)
            begin
                acc_reg[prod_dst_reg] <= prod_neg_reg
                    ? acc_reg[prod_dst_reg] - AccW'(prod_reg)
                    : acc_reg[prod_dst_reg] + AccW'(prod_reg);
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        err_reg   <= job.err;
                        total_reg <= job.total;
                        j_reg     <= 6'd0;
                        state_reg <= job.err ? S_EMIT : S_RD_G;
                    end
                end
                S_RD_G:
                begin
                    state_reg <= S_RD_P;
                end
                S_RD_P:
                begin
                    state_reg <= S_SEL;
                end
                S_SEL:
                begin
                    if ((j_reg == 6'd0) || par_oob)
                    begin
                        res_reg[0] <= g_reg.x;
                        res_reg[1] <= g_reg.y;
                        res_reg[2] <= g_reg.z;
                        res_reg[3] <= g_reg.w;
                        state_reg  <= S_EMIT;
                    end
                    else
                    begin
                        for (int a = 0; a < 5; a++)
                        begin
                            acc_reg[a] <= '0;
                        end
                        k_reg     <= 5'd0;
                        state_reg <= S_MAC;
                    end
                end
                S_MAC:
                begin
                    prod_reg     <= mul_p;
                    prod_neg_reg <= mt.neg;
                    prod_dst_reg <= mt.dst;
                    k_reg        <= k_reg + 5'd1;
                    if (k_reg == skl_g2l_pkg::MAC_STEPS - 5'd1)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    c_reg     <= 2'd0;
                    state_reg <= S_DSET;
                end
                S_DSET:
                begin
                    neg_reg <= h_cur < 0;
                    if (n_cur == '0)
                    begin
                        res_reg[c_reg] <= '0;
                        c_reg          <= c_reg + 2'd1;
                        state_reg      <= (c_reg == 2'd3) ? S_EMIT : S_DSET;
                    end
                    else if ({2'b00, mag} >= {n_cur, 2'b00})
                    begin
                        // Quotient at least 2^CW: saturate straight away.
                        res_reg[c_reg] <= (h_cur < 0) ? {1'b1, {(CW-1){1'b0}}}
                                                      : {1'b0, {(CW-1){1'b1}}};
                        c_reg          <= c_reg + 2'd1;
                        state_reg      <= (c_reg == 2'd3) ? S_EMIT : S_DSET;
                    end
                    else
                    begin
                        rem_reg   <= DivW'({mag, {skl_g2l_pkg::FRAC_BITS{1'b0}}});
                        dv_reg    <= DivW'({n_cur, {(CW-1){1'b0}}});
                        q_reg     <= '0;
                        i_reg     <= 4'(CW - 1);
                        state_reg <= S_DIT;
                    end
                end
                S_DIT:
                begin
                    if (ge)
                    begin
                        rem_reg <= rem_reg - dv_reg;
                    end
                    dv_reg <= dv_reg >> 1;
                    q_reg  <= qf;
                    i_reg  <= i_reg - 4'd1;
                    if (i_reg == 4'd0)
                    begin
                        res_reg[c_reg] <= qres;
                        c_reg          <= c_reg + 2'd1;
                        state_reg      <= (c_reg == 2'd3) ? S_EMIT : S_DSET;
                    end
                end
                S_EMIT:
                begin
                    if (emit_go)
                    begin
                        out_valid_reg <= 1'b1;
                        if (err_reg)
                        begin
                            out_reg   <= '{out_joint: 5'd0, lx: '0, ly: '0, lz: '0,
                                           lw: '0, run_end: 1'b1, count_error: 1'b1};
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            out_reg   <= '{out_joint: j_reg[4:0], lx: res_reg[0],
                                           ly: res_reg[1], lz: res_reg[2],
                                           lw: res_reg[3], run_end: last_joint,
                                           count_error: 1'b0};
                            j_reg     <= j_reg + 6'd1;
                            state_reg <= last_joint ? S_IDLE : S_RD_G;
                        end
                    end
                    else if (out_valid_reg && !result_stall)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/skl_g2l_checker.sv
// Port-level checker of the rotation core and its bind.
`include "skeleton_global_to_local_rotation_core_defines.svh"

module skl_g2l_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 item_valid,
    input logic                 item_stall,
    input skl_g2l_pkg::item_t   item,
    input logic                 result_valid,
    input logic                 result_stall,
    input skl_g2l_pkg::result_t result
);

    // A result that is not taken stays offered.
    `SKL_G2L_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid, "result dropped while stalled")

    // An error result is a lone, empty last result.
    `SKL_G2L_ASSERT_NOW(a_error_shape, result_valid && result.count_error, result.run_end && (result.out_joint == 5'd0) && (result.lx == 16'sd0) && (result.lw == 16'sd0), "malformed count error result")

    // Once a frame closes, the table is locked against new items.
    `SKL_G2L_ASSERT_NEXT(a_lock_after_frame, item_valid && !item_stall && item.frame_end, item_stall, "item accepted right after frame end")

endmodule

bind skeleton_global_to_local_rotation_core skl_g2l_checker u_skl_g2l_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

### test/skeleton_global_to_local_rotation_core_tb.sv
// Self-checking testbench of the skeleton global-to-local joint rotation core.
`timescale 1ns / 1ps

module skeleton_global_to_local_rotation_core_tb;

    localparam int NJ = 32;

    logic                 clk;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_stall;
    skl_g2l_pkg::item_t   item;
    logic                 result_valid;
    logic                 result_stall;
    skl_g2l_pkg::result_t result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [5:0]           cfg_data;

    skeleton_global_to_local_rotation_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // Requests waiting to be sent, and local rotations the core owes us.
    skl_g2l_pkg::item_t   joint_queue[$];
    skl_g2l_pkg::result_t local_queue[$];
    int      error_count;
    bit      quiet_phase;
    bit      hold_sender;

    // Shadow copy of the core's state, used to predict the locals.
    logic signed [15:0] shadow_q[NJ][4];
    logic [4:0]         shadow_parent[NJ];
    int                 shadow_count;
    int                 shadow_total;

    always #10 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Scaled quotient h * 2^14 / n, truncated toward zero, then saturated.
    function automatic logic signed [15:0] scaled_quotient(longint h, longint n);
        longint q;
        q = (h * 64'sd16384) / n;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    // Computes the local rotation of one joint from the shadow tables.
    function automatic skl_g2l_pkg::result_t local_rotation(int j, int total);
        skl_g2l_pkg::result_t r;
        longint gx, gy, gz, gw, ax, ay, az, aw, n;
        int p;
        r = '0;
        r.out_joint = j[4:0];
        r.run_end = (j == total - 1);
        p = shadow_parent[j];
        gx = shadow_q[j][0]; gy = shadow_q[j][1];
        gz = shadow_q[j][2]; gw = shadow_q[j][3];
        if (j == 0 || p >= NJ) begin
            r.lx = shadow_q[j][0]; r.ly = shadow_q[j][1];
            r.lz = shadow_q[j][2]; r.lw = shadow_q[j][3];
            return r;
        end
        ax = -longint'(shadow_q[p][0]);
        ay = -longint'(shadow_q[p][1]);
        az = -longint'(shadow_q[p][2]);
        aw = shadow_q[p][3];
        n = ax * ax + ay * ay + az * az + aw * aw;
        if (n == 0) return r;
        r.lx = scaled_quotient(aw * gx + ax * gw + ay * gz - az * gy, n);
        r.ly = scaled_quotient(aw * gy + ay * gw + az * gx - ax * gz, n);
        r.lz = scaled_quotient(aw * gz + az * gw + ax * gy - ay * gx, n);
        r.lw = scaled_quotient(aw * gw - ax * gx - ay * gy - az * gz, n);
        return r;
    endfunction

    // Updates the shadow state with one accepted request and queues its results.
    task automatic predict_locals(input skl_g2l_pkg::item_t it);
        skl_g2l_pkg::result_t r;
        int k;
        shadow_q[it.joint_index][0] = it.qx;
        shadow_q[it.joint_index][1] = it.qy;
        shadow_q[it.joint_index][2] = it.qz;
        shadow_q[it.joint_index][3] = it.qw;
        shadow_parent[it.joint_index] = it.parent_index;
        if (shadow_count < 63) shadow_count++;
        if (!it.frame_end) return;
        k = shadow_count;
        shadow_count = 0;
        if (k != shadow_total || shadow_total == 0 || shadow_total > NJ) begin
            r = '0;
            r.run_end = 1'b1;
            r.count_error = 1'b1;
            local_queue = {local_queue, r};
        end else begin
            for (int j = 0; j < shadow_total; j++)
                local_queue = {local_queue, local_rotation(j, shadow_total)};
        end
    endtask

    // Driver: presents queued requests with random idle bursts between them.
    int send_gap;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            item_valid <= 1'b0;
            item       <= '0;
            send_gap   <= 0;
        end else begin
            if (item_valid && !item_stall) begin
                predict_locals(item);
                void'(joint_queue.pop_front());
            end
            if (item_valid && item_stall) begin
                // Hold the stalled request as it is.
            end else if (send_gap > 0) begin
                send_gap   <= send_gap - 1;
                item_valid <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
                send_gap   <= $urandom_range(1, 19) - 1;
                item_valid <= 1'b0;
            end else if (joint_queue.size() > 0 && !hold_sender) begin
                item_valid <= 1'b1;
                item       <= joint_queue[0];
            end else begin
                item_valid <= 1'b0;
            end
        end
    end

    // Monitor: takes each accepted local and checks it against the oldest one owed.
    int stall_left;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            result_stall <= 1'b0;
            stall_left   <= 0;
        end else begin
            if (result_valid && !result_stall) begin
                if (local_queue.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    skl_g2l_pkg::result_t e;
                    e = local_queue.pop_front();
                    if (result.out_joint !== e.out_joint)
                        report_mismatch($sformatf("out_joint %0d want %0d",
                                                  result.out_joint, e.out_joint));
                    if (result.lx !== e.lx)
                        report_mismatch($sformatf("lx %0d want %0d", result.lx, e.lx));
                    if (result.ly !== e.ly)
                        report_mismatch($sformatf("ly %0d want %0d", result.ly, e.ly));
                    if (result.lz !== e.lz)
                        report_mismatch($sformatf("lz %0d want %0d", result.lz, e.lz));
                    if (result.lw !== e.lw)
                        report_mismatch($sformatf("lw %0d want %0d", result.lw, e.lw));
                    if (result.run_end !== e.run_end)
                        report_mismatch($sformatf("run_end %0b want %0b",
                                                  result.run_end, e.run_end));
                    if (result.count_error !== e.count_error)
                        report_mismatch($sformatf("count_error %0b want %0b",
                                                  result.count_error, e.count_error));
                end
            end
            if (stall_left > 0) begin
                stall_left   <= stall_left - 1;
                result_stall <= 1'b1;
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                stall_left   <= $urandom_range(1, 19) - 1;
                result_stall <= 1'b1;
            end else begin
                result_stall <= 1'b0;
            end
        end
    end

    // Random component, biased toward the extremes now and then.
    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'h4000;
            4: return 16'hc000;
            default: return 16'($urandom_range(0, 16'hffff));
        endcase
    endfunction

    function automatic skl_g2l_pkg::item_t make_joint(int j, int p, bit last);
        skl_g2l_pkg::item_t it;
        it.joint_index  = j[4:0];
        it.parent_index = p[4:0];
        it.qx = rand_comp(); it.qy = rand_comp();
        it.qz = rand_comp(); it.qw = rand_comp();
        it.frame_end = last;
        return it;
    endfunction

    // Queues one well-formed frame: joints 0..n-1, each parent below itself.
    // The parent field is random for the root since the core ignores it there.
    task automatic queue_frame(input int n);
        int p;
        for (int j = 0; j < n; j++) begin
            p = (j == 0) ? $urandom_range(0, 31) : $urandom_range(0, j - 1);
            joint_queue = {joint_queue, make_joint(j, p, j == n - 1)};
        end
    endtask

    // Waits until the core has sent everything, then lets its longest local finish.
    task automatic wait_drained();
        while (joint_queue.size() > 0 || item_valid || local_queue.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // Writes joint_total through the config channel while the core is idle.
    task automatic write_total(input logic [5:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        shadow_total = v;
        cfg_valid <= 1'b0;
    endtask

    // Queues a frame whose joints may be unloaded only if they were loaded before.
    task automatic queue_odd_frame(input int n);
        int j, p;
        for (int k = 0; k < n; k++) begin
            j = $urandom_range(0, 31);
            p = $urandom_range(0, 31);
            joint_queue = {joint_queue, make_joint(j, p, k == n - 1)};
        end
    endtask

    int phase_total;
    int items_sent;

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        error_count = 0;
        quiet_phase = 1'b0;
        hold_sender = 1'b0;
        shadow_count = 0;
        shadow_total = 1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: fill the whole table once so later frames never read stale
        // unwritten entries, with a zero-norm parent.
        write_total(6'd32);
        for (int j = 0; j < 32; j++) begin
            skl_g2l_pkg::item_t it;
            it = make_joint(j, (j == 0) ? 0 : j - 1, j == 31);
            if (j == 3) begin
                it.qx = '0; it.qy = '0; it.qz = '0; it.qw = '0;
            end
            joint_queue = {joint_queue, it};
        end
        wait_drained();

        // Count mismatches, then the reset-value frame size.
        queue_frame(5);
        wait_drained();
        write_total(6'd0);
        queue_frame(1);
        wait_drained();
        write_total(6'd63);
        queue_frame(2);
        wait_drained();
        write_total(6'd1);
        queue_frame(1);
        joint_queue = {joint_queue, make_joint(0, 31, 1'b1)};
        wait_drained();

        // Random phases with varied frame sizes; mostly small frames.
        items_sent = 0;
        while (items_sent < 400) begin
            case ($urandom_range(0, 5))
                0: phase_total = 32;
                1: phase_total = 1;
                default: phase_total = $urandom_range(2, 8);
            endcase
            if (items_sent > 330) quiet_phase = 1'b1;
            write_total(phase_total[5:0]);
            for (int f = 0; f < 4; f++) begin
                int r;
                int m;
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    m = $urandom_range(1, 4);
                    queue_odd_frame(m);
                    items_sent += m;
                end else if (r == 1) begin
                    queue_odd_frame(phase_total);
                    items_sent += phase_total;
                end else begin
                    queue_frame(phase_total);
                    items_sent += phase_total;
                end
                // In early phases the sender holds off once until the core has caught up.
                if (f == 1 && items_sent < 100) begin
                    while (joint_queue.size() > 0 || item_valid) @(posedge clk);
                    hold_sender = 1'b1;
                    while (local_queue.size() > 0) @(posedge clk);
                    hold_sender = 1'b0;
                end
            end
            wait_drained();
        end

        if (error_count == 0 && local_queue.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #40ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/skl_g2l_pkg.sv
rtl/skl_g2l_front.sv
rtl/skl_g2l_jobq.sv
rtl/skl_g2l_back.sv
rtl/skeleton_global_to_local_rotation_core.sv
rtl/skl_g2l_checker.sv
test/skeleton_global_to_local_rotation_core_tb.sv
